FILE: design/circular_doubly_linked_list_assert.svh
// Assertion macros shared by the list design.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CDLL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define CDLL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Types and constants shared by the circular linked list design.
// ----------------------------------------------------------------------------
package cdll_pkg;
    localparam int NODES_DEF      = 255;
    localparam int VALUE_BITS_DEF = 32;
    localparam int REQ_W          = 3;
    localparam int IN_VALUE_W     = 32;
    localparam int HANDLE_W       = 8;
    localparam int STATUS_W       = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4,
        REQ_DELETE     = 3'd5,
        REQ_FIND       = 3'd6,
        REQ_NOP        = 3'd7
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD       = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RD0,
        S_CHECK,
        S_RDPOS,
        S_LINK,
        S_RDNODE,
        S_UNLINK,
        S_FWAIT,
        S_FCMP,
        S_DONE
    } fsm_t;
endpackage

FILE: design/cdll_ram.sv
// ----------------------------------------------------------------------------
// cdll_ram
// Generic synchronous RAM with one write port, one read port and a registered read.
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/circular_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list
// Bounded circular doubly linked list with a sentinel in slot 0.
// ----------------------------------------------------------------------------
// One request is handled at a time. Push and insert go through S_RD0,
// S_CHECK, S_RDPOS, S_LINK, S_UNLINK and S_DONE; pop and delete through
// S_RD0, S_CHECK, S_RDNODE, S_UNLINK and S_DONE; a request refused by its
// checks (or the ignored request kind) goes from S_CHECK to S_DONE. Steps
// are set by the single read port of each link memory, which is read one
// address per cycle and written back. Find walks the list from the front,
// one node per S_FWAIT and S_FCMP pass, until a match, the sentinel or count
// nodes walked. After reset a clearing pass initializes the free stack and
// the sentinel links; no request is accepted during it. Slots used are kept
// in one flip-flop each. Results wait in an output register; the next
// request is accepted only after the previous result has been taken.
module circular_doubly_linked_list #(
    parameter int NODES      = cdll_pkg::NODES_DEF,
    parameter int VALUE_BITS = cdll_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type [2:0], value [34:3], handle [42:35], zero pad [47:43]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [2:0], result_handle [10:3], element_count [18:11], pad [23:19]
    output logic [23:0] m_tdata
);
    import cdll_pkg::*;
    `include "circular_doubly_linked_list_assert.svh"

    localparam int SLOTS = NODES + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    fsm_t state_reg, state_next;
    req_t req_reg, req_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [HANDLE_W-1:0]   h_reg, h_next;
    logic [AW-1:0] pos_reg, pos_next, bef_reg, bef_next, node_reg, node_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] cnt_reg, cnt_next, top_reg, top_next, walk_reg, walk_next;
    logic [AW:0]   init_reg, init_next;
    logic [1:0]    sub_reg, sub_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [HANDLE_W-1:0] rh_reg, rh_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic out_v_reg, out_v_next;
    logic [23:0] out_d_reg, out_d_next;

    // Memory ports
    logic nx_we, pv_we, vl_we, fs_we;
    logic [AW-1:0] nx_wa, nx_wd, nx_ra, pv_wa, pv_wd, pv_ra, vl_wa, vl_ra;
    logic [AW-1:0] fs_wa, fs_wd, fs_ra, nx_rd, pv_rd, fs_rd;
    logic [VALUE_BITS-1:0] vl_wd, vl_rd;

    cdll_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next (.aclk, .we(nx_we), .waddr(nx_wa),
        .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    cdll_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prev (.aclk, .we(pv_we), .waddr(pv_wa),
        .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
    cdll_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (.aclk, .we(vl_we),
        .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));
    cdll_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_free (.aclk, .we(fs_we), .waddr(fs_wa),
        .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

    logic h_in;
    assign h_in = ({{(32-HANDLE_W){1'b0}}, h_reg} <= 32'(NODES));

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            cnt_reg   <= '0;
            top_reg   <= CW'(NODES);
            used_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            used_reg  <= used_next;
            out_v_reg <= out_v_next;
        end
        req_reg <= req_next;  val_reg <= val_next;  h_reg <= h_next;
        pos_reg <= pos_next;  bef_reg <= bef_next;  node_reg <= node_next;
        cur_reg <= cur_next;  walk_reg <= walk_next; sub_reg <= sub_next;
        st_reg <= st_next;    rh_reg <= rh_next;    out_d_reg <= out_d_next;
    end

    always_comb begin
        state_next = state_reg; init_next = init_reg; cnt_next = cnt_reg;
        top_next = top_reg; used_next = used_reg; out_v_next = out_v_reg;
        req_next = req_reg; val_next = val_reg; h_next = h_reg;
        pos_next = pos_reg; bef_next = bef_reg; node_next = node_reg;
        cur_next = cur_reg; walk_next = walk_reg; sub_next = sub_reg;
        st_next = st_reg; rh_next = rh_reg; out_d_next = out_d_reg;
        nx_we = 1'b0; pv_we = 1'b0; vl_we = 1'b0; fs_we = 1'b0;
        nx_wa = '0; nx_wd = '0; nx_ra = '0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
        vl_wa = '0; vl_wd = '0; vl_ra = '0; fs_wa = '0; fs_wd = '0; fs_ra = '0;
        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            S_INIT: begin
                // Stack entry i holds slot NODES - i, so slot 1 is on top.
                if (init_reg < (AW+1)'(NODES)) begin
                    fs_we = 1'b1;
                    fs_wa = AW'(init_reg);
                    fs_wd = AW'((AW+1)'(NODES) - init_reg);
                end
                nx_we = 1'b1; pv_we = 1'b1;
                if (init_reg == (AW+1)'(NODES)) begin
                    state_next = S_IDLE;
                end
                init_next = init_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_tvalid && !out_v_reg) begin
                    req_next = req_t'(s_tdata[2:0]);
                    val_next = VALUE_BITS'(s_tdata[34:3]);
                    h_next   = s_tdata[42:35];
                    st_next  = ST_OK;
                    rh_next  = '0;
                    state_next = S_RD0;
                end
            end
            S_RD0: begin
                // Fetch sentinel links and the top free slot.
                nx_ra = '0; pv_ra = '0;
                fs_ra = AW'(top_reg - 1'b1);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                node_next = fs_rd;
                state_next = S_DONE;
                case (req_reg)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
                        if (req_reg == REQ_INSERT && (!h_in ||
                            (h_reg != '0 && !used_reg[AW'(h_reg)]))) begin
                            st_next = ST_BAD;
                        end else if (top_reg == '0) begin
                            st_next = ST_FULL;
                        end else begin
                            pos_next = (req_reg == REQ_PUSH_FRONT) ? nx_rd :
                                       (req_reg == REQ_PUSH_BACK) ? '0 : AW'(h_reg);
                            state_next = S_RDPOS;
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (cnt_reg == '0) begin
                            st_next = ST_EMPTY;
                        end else begin
                            pos_next = (req_reg == REQ_POP_FRONT) ? nx_rd : pv_rd;
                            state_next = S_RDNODE;
                        end
                    end
                    REQ_DELETE: begin
                        if (!h_in || h_reg == '0 || !used_reg[AW'(h_reg)]) begin
                            st_next = ST_BAD;
                        end else begin
                            pos_next = AW'(h_reg);
                            state_next = S_RDNODE;
                        end
                    end
                    REQ_FIND: begin
                        st_next = ST_NOT_FOUND;
                        cur_next = nx_rd;
                        walk_next = '0;
                        state_next = S_FWAIT;
                    end
                    default: ;
                endcase
                sub_next = '0;
            end
            S_RDPOS: begin
                pv_ra = pos_reg;
                state_next = S_LINK;
            end
            S_LINK: begin
                nx_we = 1'b1; nx_wa = pv_rd;   nx_wd = node_reg;
                pv_we = 1'b1; pv_wa = pos_reg; pv_wd = node_reg;
                vl_we = 1'b1; vl_wa = node_reg; vl_wd = val_reg;
                bef_next = pv_rd;
                used_next[node_reg] = 1'b1;
                top_next = top_reg - 1'b1;
                cnt_next = cnt_reg + 1'b1;
                rh_next = HANDLE_W'(node_reg);
                state_next = S_UNLINK;
                sub_next = 2'd1;
            end
            S_RDNODE: begin
                nx_ra = pos_reg; pv_ra = pos_reg;
                state_next = S_UNLINK;
                sub_next = 2'd0;
            end
            S_UNLINK: begin
                if (sub_reg == 2'd1) begin
                    // Second half of a link: the new node's own links.
                    nx_we = 1'b1; nx_wa = node_reg; nx_wd = pos_reg;
                    pv_we = 1'b1; pv_wa = node_reg; pv_wd = bef_reg;
                end else begin
                    nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                    pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                    fs_we = 1'b1; fs_wa = AW'(top_reg); fs_wd = pos_reg;
                    used_next[pos_reg] = 1'b0;
                    top_next = top_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_FWAIT: begin
                if (walk_reg >= cnt_reg || cur_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    nx_ra = cur_reg; vl_ra = cur_reg;
                    state_next = S_FCMP;
                end
            end
            S_FCMP: begin
                if (vl_rd == val_reg) begin
                    st_next = ST_OK;
                    rh_next = HANDLE_W'(cur_reg);
                    state_next = S_DONE;
                end else begin
                    cur_next = nx_rd;
                    walk_next = walk_reg + 1'b1;
                    state_next = S_FWAIT;
                end
            end
            S_DONE: begin
                if (!out_v_reg) begin
                    out_v_next = 1'b1;
                    out_d_next = {5'd0, 8'(cnt_reg), rh_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `CDLL_ASSERT_IMP(a_cnt_top, aclk, aresetn, state_reg == S_IDLE, (cnt_reg + top_reg) == CW'(NODES), "count plus free slots must equal NODES")
    `CDLL_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready, "request accepted while busy")
    `CDLL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
endmodule
